// ===== design/rdq_pkg.sv =====
// Shared types, constants and ring helper for the ring deque store.
package rdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int Q_DEPTH    = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_IDX   = 3'd4,
        OP_WRITE_IDX  = 3'd5,
        OP_NOP        = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_RANGE     = 2'd2,
        ST_OVERWRITE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_REPORT
    } bk_state_t;

    typedef struct packed {
        op_t                    op;
        logic [PTR_W-1:0]       position;
        logic [DATA_WIDTH-1:0]  data;
    } cmd_t;

    // Slot of an offset from the front; callers must keep head < n and off < n, which the function does not check.
    function automatic logic [PTR_W-1:0] slot_at(
        input logic [PTR_W-1:0] head,
        input logic [CNT_W-1:0] off,
        input logic [CNT_W-1:0] n
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(n)) begin
            sum = sum - (CNT_W+1)'(n);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ===== design/rdq_front.sv =====
// Front end: takes a command word, classifies its opcode and pushes it into the queue while the queue is not full.
module rdq_front
    import rdq_pkg::*;
(
    input  logic                   start,
    input  logic [2:0]             opcode,
    input  logic [PTR_W-1:0]       position,
    input  logic [DATA_WIDTH-1:0]  data_value,
    input  logic                   q_full,
    output logic                   busy,
    output logic                   q_push,
    output cmd_t                   q_cmd
);

    op_t op_kind;

    always_comb
    begin
        case (opcode)
            OP_PUSH_BACK:  op_kind = OP_PUSH_BACK;
            OP_PUSH_FRONT: op_kind = OP_PUSH_FRONT;
            OP_POP_BACK:   op_kind = OP_POP_BACK;
            OP_POP_FRONT:  op_kind = OP_POP_FRONT;
            OP_READ_IDX:   op_kind = OP_READ_IDX;
            OP_WRITE_IDX:  op_kind = OP_WRITE_IDX;
            default:       op_kind = OP_NOP;
        endcase
    end

    assign busy            = q_full;
    assign q_push          = start && !q_full;
    assign q_cmd.op        = op_kind;
    assign q_cmd.position  = position;
    assign q_cmd.data      = data_value;

endmodule

// ===== design/rdq_queue.sv =====
// Two-entry command queue between front end and back end.
module rdq_queue
    import rdq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  cmd_t  push_cmd,
    input  logic  pop,
    output cmd_t  head_cmd,
    output logic  full,
    output logic  empty
);

    cmd_t              slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_next;

    assign full     = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/rdq_back.sv =====
// Back end: ring pointers, entry memory and result reporting.
module rdq_back
    import rdq_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CNT_W-1:0]              cfg_wr_data,
    input  logic                          q_empty,
    input  cmd_t                          q_cmd,
    output logic                          q_pop,
    output logic                          done,
    output logic signed [DATA_WIDTH-1:0]  read_value,
    output logic signed [DATA_WIDTH-1:0]  front_value,
    output logic signed [DATA_WIDTH-1:0]  back_value,
    output logic [CNT_W-1:0]              occupancy,
    output logic [1:0]                    status
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    bk_state_t             state_reg, state_next;
    logic [CNT_W-1:0]      cap_reg;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    status_t               status_reg, status_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic [DATA_WIDTH-1:0] read_value_reg, read_value_next;
    logic [DATA_WIDTH-1:0] rdata_a_reg, rdata_b_reg;

    logic [CNT_W-1:0]      n_cap;
    logic [CNT_W-1:0]      offset;
    logic [PTR_W-1:0]      off_slot;
    logic [CNT_W-1:0]      back_off;
    logic [PTR_W-1:0]      back_slot;
    logic                  we;
    logic [PTR_W-1:0]      waddr;
    logic [PTR_W-1:0]      raddr_a;
    logic [PTR_W-1:0]      raddr_b;

    // capacity 0 acts as 1, anything above the depth as the depth
    always_comb
    begin
        if (cap_reg == '0)
            n_cap = CNT_W'(1);
        else if (cap_reg > CNT_W'(DEPTH))
            n_cap = CNT_W'(DEPTH);
        else
            n_cap = cap_reg;
    end

    assign off_slot  = slot_at(head_reg, offset, n_cap);
    assign back_off  = (count_reg == '0) ? '0 : count_reg - 1'b1;
    assign back_slot = slot_at(head_reg, back_off, n_cap);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        rd_ok_next      = rd_ok_reg;
        read_value_next = read_value_reg;
        q_pop           = 1'b0;
        done            = 1'b0;
        we              = 1'b0;
        offset          = '0;
        waddr           = off_slot;
        raddr_a         = head_reg;
        raddr_b         = back_slot;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    status_next = ST_OK;
                    rd_ok_next  = 1'b0;
                    state_next  = B_FETCH;
                    case (q_cmd.op)
                        OP_PUSH_BACK:
                        begin
                            we = 1'b1;
                            if (count_reg < n_cap)
                            begin
                                offset     = count_reg;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                offset      = count_reg - 1'b1;
                                status_next = ST_OVERWRITE;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            we = 1'b1;
                            if (count_reg < n_cap)
                            begin
                                head_next  = (head_reg == '0) ? PTR_W'(n_cap - 1'b1)
                                                              : head_reg - 1'b1;
                                waddr      = head_next;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                waddr       = head_reg;
                                status_next = ST_OVERWRITE;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                                count_next = count_reg - 1'b1;
                        end
                        OP_POP_FRONT:
                        begin
                            offset = CNT_W'(1);
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = off_slot;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_READ_IDX:
                        begin
                            offset  = CNT_W'(q_cmd.position);
                            raddr_a = off_slot;
                            if (CNT_W'(q_cmd.position) >= count_reg)
                                status_next = ST_RANGE;
                            else
                                rd_ok_next = 1'b1;
                        end
                        OP_WRITE_IDX:
                        begin
                            offset = CNT_W'(q_cmd.position);
                            if (CNT_W'(q_cmd.position) >= count_reg)
                                status_next = ST_RANGE;
                            else
                                we = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_FETCH:
            begin
                // port A now holds the indexed entry; reissue for front and back
                read_value_next = rd_ok_reg ? rdata_a_reg : '0;
                raddr_a         = head_reg;
                raddr_b         = back_slot;
                state_next      = B_REPORT;
            end
            B_REPORT:
            begin
                done       = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            cap_reg    <= CNT_W'(DEPTH);
            head_reg   <= '0;
            count_reg  <= '0;
            status_reg <= ST_OK;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            rd_ok_reg  <= rd_ok_next;
            if (cfg_wr_en)
            begin
                cap_reg   <= cfg_wr_data;
                head_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= q_cmd.data;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign read_value  = read_value_reg;
    assign front_value = (count_reg == '0) ? '0 : rdata_a_reg;
    assign back_value  = (count_reg == '0) ? '0 : rdata_b_reg;
    assign occupancy   = count_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    a_count_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= n_cap)
        else $error("element count exceeds ring size");

    a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < PTR_W'(n_cap - 1'b1) || head_reg == PTR_W'(n_cap - 1'b1))
        else $error("head pointer outside ring");

    a_done_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == B_FETCH))
        else $error("result word without fetch cycle");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == B_FETCH)
        else $error("command taken outside idle");
`endif

endmodule

// ===== design/ring_deque_store_unit.sv =====
// Ring deque store: takes one command word after another; each command word
// leaves the queue and runs in the back end through its execute and write,
// fetch front and back, and report states, as the two-port entry memory has
// registered reads. The back end takes a new command word only after it has
// reported the last one; the two-entry command queue keeps busy low until
// two commands wait. The result word appears on the done strobe for exactly
// one cycle and cannot be held off, so the receiver must take it then;
// results come in command order. Writing capacity empties the store.
module ring_deque_store_unit
    import rdq_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    opcode,
    input  logic [PTR_W-1:0]              position,
    input  logic signed [DATA_WIDTH-1:0]  data_value,
    input  logic                          cfg_wr_en,
    input  logic [CNT_W-1:0]              cfg_wr_data,
    output logic                          done,
    output logic signed [DATA_WIDTH-1:0]  read_value,
    output logic signed [DATA_WIDTH-1:0]  front_value,
    output logic signed [DATA_WIDTH-1:0]  back_value,
    output logic [CNT_W-1:0]              occupancy,
    output logic [1:0]                    status
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    rdq_front u_front (
        .start      (start),
        .opcode     (opcode),
        .position   (position),
        .data_value (data_value),
        .q_full     (q_full),
        .busy       (busy),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    rdq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    rdq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .done        (done),
        .read_value  (read_value),
        .front_value (front_value),
        .back_value  (back_value),
        .occupancy   (occupancy),
        .status      (status)
    );

endmodule

// ===== verif/tb_ring_deque_store_unit.sv =====
// Self-checking testbench for ring_deque_store_unit: random deque traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_ring_deque_store_unit;
    import rdq_pkg::*;

    localparam logic [2:0] OP_SPARE  = 3'd7;  // second unused opcode
    localparam int         N_PHASES  = 14;
    localparam int         PRINT_MAX = 50;

    typedef struct {
        logic [2:0]            op;
        logic [PTR_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] data;
    } cmd_word_t;

    typedef struct {
        logic [DATA_WIDTH-1:0] read_val;
        logic [DATA_WIDTH-1:0] front_val;
        logic [DATA_WIDTH-1:0] back_val;
        logic [CNT_W-1:0]      occ;
        status_t               st;
    } deque_result_t;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         start       = 1'b0;
    logic [2:0]                   opcode      = '0;
    logic [PTR_W-1:0]             position    = '0;
    logic signed [DATA_WIDTH-1:0] data_value  = '0;
    logic                         cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]             cfg_wr_data = '0;
    logic                         busy;
    logic                         done;
    logic signed [DATA_WIDTH-1:0] read_value;
    logic signed [DATA_WIDTH-1:0] front_value;
    logic signed [DATA_WIDTH-1:0] back_value;
    logic [CNT_W-1:0]             occupancy;
    logic [1:0]                   status;

    ring_deque_store_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .position    (position),
        .data_value  (data_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .read_value  (read_value),
        .front_value (front_value),
        .back_value  (back_value),
        .occupancy   (occupancy),
        .status      (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state: shadow ring, pointers and capacity setting.
    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
    int                    ring_head;
    int                    ring_count;
    logic [CNT_W-1:0]      cap_setting = CNT_W'(16);

    cmd_word_t     pending_words[$];
    deque_result_t expected_results[$];
    cmd_word_t     drive_word;
    int            gap_left;
    bit            idle_bursts;
    int            mismatch_count;
    int            results_checked;
    int            words_sent;
    int            status_seen[4];

    function automatic int ring_slots(input logic [CNT_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > DEPTH)
            return DEPTH;
        return int'(c);
    endfunction

    function automatic int ring_slot(input int off);
        int n;
        int s;
        n = ring_slots(cap_setting);
        s = (ring_head % n) + (off % n);
        if (s >= n)
            s -= n;
        return s;
    endfunction

    task automatic predict_result(input logic [2:0] op, input logic [PTR_W-1:0] pos,
                                  input logic [DATA_WIDTH-1:0] dv);
        deque_result_t r;
        int            n;
        n = ring_slots(cap_setting);
        r.read_val  = '0;
        r.front_val = '0;
        r.back_val  = '0;
        r.st        = ST_OK;
        case (op)
            OP_PUSH_BACK:
                if (ring_count < n)
                begin
                    ring_mem[ring_slot(ring_count)] = dv;
                    ring_count++;
                end
                else
                begin
                    ring_mem[ring_slot(ring_count - 1)] = dv;
                    r.st = ST_OVERWRITE;
                end
            OP_PUSH_FRONT:
                if (ring_count < n)
                begin
                    ring_head = (ring_head == 0) ? n - 1 : ring_head - 1;
                    ring_mem[ring_head] = dv;
                    ring_count++;
                end
                else
                begin
                    ring_mem[ring_head] = dv;
                    r.st = ST_OVERWRITE;
                end
            OP_POP_BACK:
                if (ring_count == 0)
                    r.st = ST_EMPTY;
                else
                    ring_count--;
            OP_POP_FRONT:
                if (ring_count == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    ring_head = ring_slot(1);
                    ring_count--;
                end
            OP_READ_IDX:
                if (int'(pos) >= ring_count)
                    r.st = ST_RANGE;
                else
                    r.read_val = ring_mem[ring_slot(int'(pos))];
            OP_WRITE_IDX:
                if (int'(pos) >= ring_count)
                    r.st = ST_RANGE;
                else
                    ring_mem[ring_slot(int'(pos))] = dv;
            default:
                ;
        endcase
        if (ring_count != 0)
        begin
            r.front_val = ring_mem[ring_head];
            r.back_val  = ring_mem[ring_slot(ring_count - 1)];
        end
        r.occ = CNT_W'(ring_count);
        status_seen[r.st]++;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] exp_v,
                                   input logic [DATA_WIDTH-1:0] got_v);
        if (mismatch_count < PRINT_MAX)
            $display("ERROR result %0d %s: expected %h got %h", results_checked, what,
                     exp_v, got_v);
        mismatch_count++;
    endtask

    // Driver: presents the next pending word, holds it while busy, random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            opcode     <= '0;
            position   <= '0;
            data_value <= '0;
            gap_left    = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_result(opcode, position, data_value);
                words_sent++;
                if (idle_bursts && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 9);
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    start <= 1'b0;
                    gap_left--;
                end
                else if (pending_words.size() > 0)
                begin
                    drive_word  = pending_words.pop_front();
                    opcode     <= drive_word.op;
                    position   <= drive_word.pos;
                    data_value <= drive_word.data;
                    start      <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        deque_result_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected word, read_value", '0, read_value);
            else
            begin
                e = expected_results.pop_front();
                if (read_value !== e.read_val)
                    report_mismatch("read_value", e.read_val, read_value);
                if (front_value !== e.front_val)
                    report_mismatch("front_value", e.front_val, front_value);
                if (back_value !== e.back_val)
                    report_mismatch("back_value", e.back_val, back_value);
                if (occupancy !== e.occ)
                    report_mismatch("occupancy", DATA_WIDTH'(e.occ), DATA_WIDTH'(occupancy));
                if (status !== e.st)
                    report_mismatch("status", DATA_WIDTH'(e.st), DATA_WIDTH'(status));
            end
            results_checked++;
        end
    end

    task automatic queue_word(input logic [2:0] op, input logic [PTR_W-1:0] pos,
                              input logic [DATA_WIDTH-1:0] data);
        cmd_word_t w;
        w.op   = op;
        w.pos  = pos;
        w.data = data;
        pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || start || expected_results.size() != 0);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cap_setting  = value;
        ring_head    = 0;
        ring_count   = 0;
    endtask

    initial
    begin
        #2_400_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int         cap_plan[N_PHASES];
        int         n_random;
        int         slots_now;
        int         roll;
        bit         fill_mode;
        logic [2:0] op;
        cap_plan = '{16, 1, 0, 31, 2, 16, 17, 3, 5, 16, 8, 1, 15, 16};
        cap_plan[12] = $urandom_range(0, 31);
        fill_mode = 1'b1;
        idle_bursts = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            // phase 0 runs on the capacity left by reset
            if (ph > 0)
                write_capacity(CNT_W'(cap_plan[ph]));
            idle_bursts = (ph < N_PHASES - 2) && (ph % 4 != 3);
            slots_now = ring_slots(cap_setting);
            if (ph == 0)
            begin
                // empty store corner cases, then extremes of data and position
                queue_word(OP_POP_BACK, 4'd0, 32'h0);
                queue_word(OP_POP_FRONT, 4'd15, 32'hFFFF_FFFF);
                queue_word(OP_READ_IDX, 4'd0, 32'h0);
                queue_word(OP_WRITE_IDX, 4'd0, 32'h1234_5678);
                queue_word(OP_NOP, 4'd5, 32'hDEAD_BEEF);
                queue_word(OP_SPARE, 4'd10, 32'h5555_5555);
                queue_word(OP_PUSH_BACK, 4'd0, 32'h7FFF_FFFF);
                queue_word(OP_PUSH_FRONT, 4'd15, 32'h8000_0000);
                queue_word(OP_PUSH_BACK, 4'd0, 32'hFFFF_FFFF);
                queue_word(OP_PUSH_FRONT, 4'd0, 32'h0000_0000);
                queue_word(OP_READ_IDX, 4'd3, 32'h0);
                queue_word(OP_READ_IDX, 4'd4, 32'h0);
                queue_word(OP_WRITE_IDX, 4'd1, 32'hAAAA_AAAA);
                queue_word(OP_WRITE_IDX, 4'd15, 32'h5555_5555);
                queue_word(OP_READ_IDX, 4'd15, 32'h0);
                queue_word(OP_READ_IDX, 4'd1, 32'h0);
            end
            else if (ph == 1)
            begin
                // single slot: every push onto a full slot overwrites
                queue_word(OP_PUSH_BACK, 4'd0, 32'h0000_0001);
                queue_word(OP_PUSH_BACK, 4'd0, 32'h0000_0002);
                queue_word(OP_PUSH_FRONT, 4'd0, 32'h0000_0003);
                queue_word(OP_READ_IDX, 4'd0, 32'h0);
                queue_word(OP_POP_FRONT, 4'd0, 32'h0);
                queue_word(OP_POP_BACK, 4'd0, 32'h0);
                queue_word(OP_PUSH_FRONT, 4'd0, 32'h8000_0000);
                queue_word(OP_POP_BACK, 4'd0, 32'h0);
            end
            n_random = (ph < 2) ? 50 : 60;
            for (int i = 0; i < n_random; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    fill_mode = !fill_mode;
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    op = $urandom_range(0, 1) ? OP_NOP : OP_SPARE;
                else if (roll < 30)
                    op = $urandom_range(0, 1) ? OP_READ_IDX : OP_WRITE_IDX;
                else if (roll < (fill_mode ? 85 : 45))
                    op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                else
                    op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
                queue_word(op,
                           PTR_W'($urandom_range(0, 1) ? $urandom_range(0, slots_now - 1)
                                                       : $urandom_range(0, 15)),
                           $urandom);
            end
            wait_drained();
        end

        repeat (24) @(posedge clk);
        $display("Sent %0d command words over %0d capacity settings; %0d results checked.",
                 words_sent, N_PHASES, results_checked);
        $display("Status mix: ok %0d, pop on empty %0d, out of range %0d, overwrite %0d.",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
                 status_seen[ST_OVERWRITE]);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== ring_deque_store_unit.f =====
design/rdq_pkg.sv
design/rdq_front.sv
design/rdq_queue.sv
design/rdq_back.sv
design/ring_deque_store_unit.sv
verif/tb_ring_deque_store_unit.sv
